[design/svit_pkg.sv]
package svit_pkg;

    localparam int MAX_TIME     = 64;
    localparam int MAX_SEGMENTS = 8;
    localparam int MAX_CENTERS  = 8;
    localparam int SCORE_W      = 32;

    localparam int ST_N      = MAX_SEGMENTS + 1;
    localparam int ROW_N     = ST_N * MAX_CENTERS;
    localparam int EM_DEPTH  = (MAX_TIME + 1) * MAX_CENTERS;
    localparam int TR_DEPTH  = (MAX_TIME + 1) * ST_N * MAX_CENTERS;
    localparam int FWD_DEPTH = 2 * ROW_N;

    localparam int TIME_W = 7;
    localparam int SEG_W  = 4;
    localparam int CIDX_W = 3;
    localparam int CNT_W  = 4;
    localparam int BP_W   = 4;

    localparam int EM_AW   = $clog2(EM_DEPTH);
    localparam int TR_AW   = $clog2(TR_DEPTH);
    localparam int FWD_AW  = $clog2(FWD_DEPTH);
    localparam int BIAS_AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

    localparam logic signed [SCORE_W-1:0] SC_INF = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SC_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_LOAD_EM   = 2'd0,
        CMD_LOAD_TR   = 2'd1,
        CMD_LOAD_BIAS = 2'd2,
        CMD_RUN       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_TIME_STEPS   = 2'd0,
        CFG_SEGMENTS     = 2'd1,
        CFG_CENTERS_USED = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_ADD1,
        ST_ADD2,
        ST_WR,
        ST_BK_RD,
        ST_BK_CMP,
        ST_TOT_RD,
        ST_TOT_CAP,
        ST_TB_RD,
        ST_TB_CAP,
        ST_EMIT,
        ST_EMIT_NP
    } state_t;

    function automatic logic signed [SCORE_W-1:0] add_score(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0] sum;
        sum = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (a == SC_INF || b == SC_INF)
            return SC_INF;
        else if (sum[SCORE_W] != sum[SCORE_W-1])
            return sum[SCORE_W] ? SC_MIN : SC_INF;
        else
            return sum[SCORE_W-1:0];
    endfunction

    function automatic logic [EM_AW-1:0] em_addr(
        input logic [TIME_W-1:0] t,
        input logic [CIDX_W-1:0] c
    );
        return EM_AW'(t) * EM_AW'(MAX_CENTERS) + EM_AW'(c);
    endfunction

    function automatic logic [TR_AW-1:0] tr_addr(
        input logic [TIME_W-1:0] t,
        input logic [SEG_W-1:0]  s,
        input logic [CIDX_W-1:0] c
    );
        return (TR_AW'(t) * TR_AW'(ST_N) + TR_AW'(s)) * TR_AW'(MAX_CENTERS) + TR_AW'(c);
    endfunction

    function automatic logic [FWD_AW-1:0] fwd_addr(
        input logic              row,
        input logic [SEG_W-1:0]  i,
        input logic [CIDX_W-1:0] c
    );
        return FWD_AW'(row) * FWD_AW'(ROW_N) + FWD_AW'(i) * FWD_AW'(MAX_CENTERS)
            + FWD_AW'(c);
    endfunction

endpackage

[design/svit_ram.sv]
module svit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/segmental_viterbi_aligner.sv]
// each cell is a read / add / add / write sequence on the forward row memory (one read port);
// a switch row first scans the previous segment's centers, with one read and one compare per center
// load transactions are accepted back to back while idle
// results leave through an output register, one per cycle while the sink is ready
// rst_n clears control registers and the output valid; score memories hold garbage until loaded
module segmental_viterbi_aligner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // time_index, state_index, center_index, value
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // segment_start, segment_center, total_score
    output logic [0:0]  m_axis_tuser,   // no_path
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int TW = svit_pkg::TIME_W;
    localparam int SW = svit_pkg::SEG_W;
    localparam int CW = svit_pkg::CIDX_W;
    localparam int NW = svit_pkg::CNT_W;
    localparam int DW = svit_pkg::SCORE_W;

    svit_pkg::state_t state_reg, state_next;

    logic [TW-1:0] time_steps_reg, time_steps_next;
    logic [SW-1:0] segments_reg, segments_next;
    logic [NW-1:0] centers_reg, centers_next;

    logic [TW-1:0] t_lim_reg, t_lim_next;
    logic [SW-1:0] s_lim_reg, s_lim_next;
    logic [NW-1:0] c_lim_reg, c_lim_next;

    logic [TW-1:0] m_reg, m_next;
    logic [SW-1:0] i_reg, i_next;
    logic [NW-1:0] c_reg, c_next;
    logic [SW-1:0] k_reg, k_next;

    logic signed [DW-1:0] back_reg, back_next;
    logic [CW-1:0]        bc_reg, bc_next;
    logic signed [DW-1:0] w_reg, w_next;
    logic signed [DW-1:0] stay_reg, stay_next;
    logic signed [DW-1:0] sw_reg, sw_next;
    logic signed [DW-1:0] total_reg, total_next;

    logic [TW-1:0] starts_reg [svit_pkg::ST_N];
    logic [TW-1:0] starts_next [svit_pkg::ST_N];
    logic [CW-1:0] cents_reg [svit_pkg::ST_N];
    logic [CW-1:0] cents_next [svit_pkg::ST_N];

    logic          out_valid_reg, out_valid_next;
    logic [TW-1:0] out_start_reg, out_start_next;
    logic [CW-1:0] out_center_reg, out_center_next;
    logic [DW-1:0] out_total_reg, out_total_next;
    logic          out_np_reg, out_np_next;
    logic          out_last_reg, out_last_next;

    // input decode
    svit_pkg::cmd_t       in_cmd;
    logic [TW-1:0]        in_ti;
    logic [SW-1:0]        in_si;
    logic [CW-1:0]        in_ci;
    logic signed [DW-1:0] in_val;
    logic                 in_fire;

    assign in_cmd  = svit_pkg::cmd_t'(s_axis_tuser);
    assign in_ti   = s_axis_tdata[6:0];
    assign in_si   = s_axis_tdata[10:7];
    assign in_ci   = s_axis_tdata[13:11];
    assign in_val  = s_axis_tdata[45:14];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // memories
    logic                          em_we, tr_we, bias_we, fwd_we, bp_we;
    logic [svit_pkg::EM_AW-1:0]    em_raddr;
    logic [svit_pkg::TR_AW-1:0]    tr_raddr, tr_waddr;
    logic [svit_pkg::FWD_AW-1:0]   fwd_raddr, fwd_waddr;
    logic signed [DW-1:0]          fwd_wdata;
    logic [svit_pkg::BP_W-1:0]     bp_wdata;
    logic [DW-1:0]                 em_rdata, tr_rdata, bias_rdata, fwd_rdata;
    logic [svit_pkg::BP_W-1:0]     bp_rdata;

    logic in_ok_t, in_ok_s, in_ok_c;
    assign in_ok_t = in_ti <= TW'(svit_pkg::MAX_TIME);
    assign in_ok_s = in_si <= SW'(svit_pkg::MAX_SEGMENTS);
    assign in_ok_c = NW'(in_ci) < NW'(svit_pkg::MAX_CENTERS);

    assign em_we    = in_fire && in_cmd == svit_pkg::CMD_LOAD_EM && in_ok_t && in_ok_c;
    assign tr_we    = in_fire && in_cmd == svit_pkg::CMD_LOAD_TR && in_ok_t && in_ok_s
                      && in_ok_c;
    assign bias_we  = in_fire && in_cmd == svit_pkg::CMD_LOAD_BIAS && in_ok_c;
    assign em_raddr = svit_pkg::em_addr(m_reg, c_reg[CW-1:0]);
    assign tr_raddr = svit_pkg::tr_addr(m_reg, i_reg, c_reg[CW-1:0]);
    assign tr_waddr = svit_pkg::tr_addr(in_ti, in_si, in_ci);
    assign fwd_waddr = svit_pkg::fwd_addr(m_reg[0], i_reg, c_reg[CW-1:0]);

    always_comb
    begin
        case (state_reg)
            svit_pkg::ST_BK_RD, svit_pkg::ST_BK_CMP:
                fwd_raddr = svit_pkg::fwd_addr(~m_reg[0], i_reg - SW'(1), c_reg[CW-1:0]);
            svit_pkg::ST_TOT_RD, svit_pkg::ST_TOT_CAP:
                fwd_raddr = svit_pkg::fwd_addr(t_lim_reg[0], s_lim_reg, CW'(0));
            default:
                fwd_raddr = svit_pkg::fwd_addr(~m_reg[0], i_reg, c_reg[CW-1:0]);
        endcase
    end

    svit_ram #(.WIDTH(DW), .DEPTH(svit_pkg::EM_DEPTH)) u_em_ram (
        .clk(clk), .we(em_we), .waddr(svit_pkg::em_addr(in_ti, in_ci)), .wdata(in_val),
        .raddr(em_raddr), .rdata(em_rdata)
    );

    svit_ram #(.WIDTH(DW), .DEPTH(svit_pkg::TR_DEPTH)) u_tr_ram (
        .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(in_val),
        .raddr(tr_raddr), .rdata(tr_rdata)
    );

    svit_ram #(.WIDTH(DW), .DEPTH(svit_pkg::MAX_CENTERS)) u_bias_ram (
        .clk(clk), .we(bias_we), .waddr(svit_pkg::BIAS_AW'(in_ci)), .wdata(in_val),
        .raddr(svit_pkg::BIAS_AW'(c_reg[CW-1:0])), .rdata(bias_rdata)
    );

    svit_ram #(.WIDTH(DW), .DEPTH(svit_pkg::FWD_DEPTH)) u_fwd_ram (
        .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
        .raddr(fwd_raddr), .rdata(fwd_rdata)
    );

    svit_ram #(.WIDTH(svit_pkg::BP_W), .DEPTH(svit_pkg::TR_DEPTH)) u_bp_ram (
        .clk(clk), .we(bp_we), .waddr(tr_raddr), .wdata(bp_wdata),
        .raddr(tr_raddr), .rdata(bp_rdata)
    );

    // helpers
    logic signed [DW-1:0] em_s, tr_s, bias_s, fwd_s;
    logic                 skip_row;
    logic                 out_free;
    logic [NW-1:0]        bp_center;

    assign em_s     = em_rdata;
    assign tr_s     = tr_rdata;
    assign bias_s   = bias_rdata;
    assign fwd_s    = fwd_rdata;
    // cells that cannot reach the final state in time
    assign skip_row = (8'(s_lim_reg) + 8'(m_reg)) > (8'(t_lim_reg) + 8'(i_reg));
    assign out_free = !out_valid_reg || m_axis_tready;
    assign bp_center = (NW'(bp_rdata) - NW'(1) >= c_lim_reg) ? NW'(0)
                                                             : NW'(bp_rdata) - NW'(1);

    always_comb
    begin
        state_next      = state_reg;
        time_steps_next = time_steps_reg;
        segments_next   = segments_reg;
        centers_next    = centers_reg;
        t_lim_next      = t_lim_reg;
        s_lim_next      = s_lim_reg;
        c_lim_next      = c_lim_reg;
        m_next          = m_reg;
        i_next          = i_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        back_next       = back_reg;
        bc_next         = bc_reg;
        w_next          = w_reg;
        stay_next       = stay_reg;
        sw_next         = sw_reg;
        total_next      = total_reg;
        starts_next     = starts_reg;
        cents_next      = cents_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_start_next  = out_start_reg;
        out_center_next = out_center_reg;
        out_total_next  = out_total_reg;
        out_np_next     = out_np_reg;
        out_last_next   = out_last_reg;
        fwd_we          = 1'b0;
        fwd_wdata       = svit_pkg::SC_INF;
        bp_we           = 1'b0;
        bp_wdata        = '0;
        s_axis_tready   = 1'b0;

        if (cfg_we)
        begin
            case (svit_pkg::cfg_idx_t'(cfg_index))
                svit_pkg::CFG_TIME_STEPS:   time_steps_next = cfg_data;
                svit_pkg::CFG_SEGMENTS:     segments_next = cfg_data[SW-1:0];
                svit_pkg::CFG_CENTERS_USED: centers_next = cfg_data[NW-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            svit_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_fire && in_cmd == svit_pkg::CMD_RUN)
                begin
                    t_lim_next = (time_steps_reg == '0) ? TW'(1)
                        : ((time_steps_reg > TW'(svit_pkg::MAX_TIME))
                            ? TW'(svit_pkg::MAX_TIME) : time_steps_reg);
                    s_lim_next = (segments_reg == '0) ? SW'(1)
                        : ((segments_reg > SW'(svit_pkg::MAX_SEGMENTS))
                            ? SW'(svit_pkg::MAX_SEGMENTS) : segments_reg);
                    c_lim_next = (centers_reg == '0) ? NW'(1)
                        : ((centers_reg > NW'(svit_pkg::MAX_CENTERS))
                            ? NW'(svit_pkg::MAX_CENTERS) : centers_reg);
                    m_next     = '0;
                    i_next     = '0;
                    c_next     = '0;
                    state_next = svit_pkg::ST_RD;
                end
            end
            svit_pkg::ST_RD:
                state_next = svit_pkg::ST_ADD1;
            svit_pkg::ST_ADD1:
            begin
                if (m_reg == '0)
                    w_next = svit_pkg::add_score(bias_s, em_s);
                else if (m_reg == t_lim_reg)
                    w_next = (c_reg == '0 && i_reg == s_lim_reg) ? '0 : svit_pkg::SC_INF;
                else if (i_reg == s_lim_reg)
                    w_next = svit_pkg::SC_INF;
                else
                    w_next = svit_pkg::add_score(em_s, tr_s);
                state_next = svit_pkg::ST_ADD2;
            end
            svit_pkg::ST_ADD2:
            begin
                // init row: start cost also takes the time-zero transition
                if (m_reg == '0)
                    stay_next = svit_pkg::add_score(w_reg, tr_s);
                else
                    stay_next = svit_pkg::add_score(w_reg, fwd_s);
                sw_next    = svit_pkg::add_score(w_reg, back_reg);
                state_next = svit_pkg::ST_WR;
            end
            svit_pkg::ST_WR:
            begin
                fwd_we = 1'b1;
                if (m_reg == '0)
                begin
                    fwd_wdata = (i_reg == '0) ? stay_reg : svit_pkg::SC_INF;
                end
                else
                begin
                    bp_we = 1'b1;
                    if (skip_row)
                    begin
                        fwd_wdata = svit_pkg::SC_INF;
                    end
                    else if (sw_reg < stay_reg)
                    begin
                        fwd_wdata = sw_reg;
                        bp_wdata  = svit_pkg::BP_W'(bc_reg) + svit_pkg::BP_W'(1);
                    end
                    else
                    begin
                        fwd_wdata = stay_reg;
                    end
                end
                if (c_reg + NW'(1) < c_lim_reg)
                begin
                    c_next     = c_reg + NW'(1);
                    state_next = svit_pkg::ST_RD;
                end
                else if (i_reg < s_lim_reg)
                begin
                    c_next     = '0;
                    i_next     = i_reg + SW'(1);
                    back_next  = svit_pkg::SC_INF;
                    bc_next    = '0;
                    state_next = (m_reg == '0) ? svit_pkg::ST_RD : svit_pkg::ST_BK_RD;
                end
                else if (m_reg < t_lim_reg)
                begin
                    c_next     = '0;
                    i_next     = '0;
                    m_next     = m_reg + TW'(1);
                    back_next  = svit_pkg::SC_INF;
                    bc_next    = '0;
                    state_next = svit_pkg::ST_RD;
                end
                else
                begin
                    state_next = svit_pkg::ST_TOT_RD;
                end
            end
            svit_pkg::ST_BK_RD:
                state_next = svit_pkg::ST_BK_CMP;
            svit_pkg::ST_BK_CMP:
            begin
                // cheapest center of the previous segment, first one wins a tie
                if (fwd_s < back_reg)
                begin
                    back_next = fwd_s;
                    bc_next   = c_reg[CW-1:0];
                end
                if (c_reg + NW'(1) < c_lim_reg)
                begin
                    c_next     = c_reg + NW'(1);
                    state_next = svit_pkg::ST_BK_RD;
                end
                else
                begin
                    c_next     = '0;
                    state_next = svit_pkg::ST_RD;
                end
            end
            svit_pkg::ST_TOT_RD:
                state_next = svit_pkg::ST_TOT_CAP;
            svit_pkg::ST_TOT_CAP:
            begin
                total_next = fwd_s;
                if (fwd_s == svit_pkg::SC_INF)
                begin
                    state_next = svit_pkg::ST_EMIT_NP;
                end
                else
                begin
                    for (int n = 0; n < svit_pkg::ST_N; n++)
                    begin
                        starts_next[n] = '0;
                        cents_next[n]  = '0;
                    end
                    m_next     = t_lim_reg;
                    i_next     = s_lim_reg;
                    c_next     = '0;
                    state_next = svit_pkg::ST_TB_RD;
                end
            end
            svit_pkg::ST_TB_RD:
            begin
                if (m_reg == '0 || i_reg == '0)
                begin
                    k_next     = '0;
                    state_next = svit_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = svit_pkg::ST_TB_CAP;
                end
            end
            svit_pkg::ST_TB_CAP:
            begin
                m_next = m_reg - TW'(1);
                if (bp_rdata != '0)
                begin
                    c_next                   = bp_center;
                    starts_next[i_reg]       = m_reg;
                    cents_next[i_reg - SW'(1)] = bp_center[CW-1:0];
                    i_next                   = i_reg - SW'(1);
                end
                state_next = svit_pkg::ST_TB_RD;
            end
            svit_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_start_next  = (k_reg == '0) ? '0 : starts_reg[k_reg];
                    out_center_next = cents_reg[k_reg];
                    out_total_next  = total_reg;
                    out_np_next     = 1'b0;
                    out_last_next   = (k_reg + SW'(1) == s_lim_reg);
                    k_next          = k_reg + SW'(1);
                    if (k_reg + SW'(1) == s_lim_reg)
                        state_next = svit_pkg::ST_IDLE;
                end
            end
            svit_pkg::ST_EMIT_NP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_start_next  = '0;
                    out_center_next = '0;
                    out_total_next  = total_reg;
                    out_np_next     = 1'b1;
                    out_last_next   = 1'b1;
                    state_next      = svit_pkg::ST_IDLE;
                end
            end
            default:
                state_next = svit_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= svit_pkg::ST_IDLE;
            time_steps_reg <= TW'(16);
            segments_reg   <= SW'(4);
            centers_reg    <= NW'(8);
            t_lim_reg      <= TW'(1);
            s_lim_reg      <= SW'(1);
            c_lim_reg      <= NW'(1);
            m_reg          <= '0;
            i_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_steps_reg <= time_steps_next;
            segments_reg   <= segments_next;
            centers_reg    <= centers_next;
            t_lim_reg      <= t_lim_next;
            s_lim_reg      <= s_lim_next;
            c_lim_reg      <= c_lim_next;
            m_reg          <= m_next;
            i_reg          <= i_next;
            c_reg          <= c_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        back_reg       <= back_next;
        bc_reg         <= bc_next;
        w_reg          <= w_next;
        stay_reg       <= stay_next;
        sw_reg         <= sw_next;
        total_reg      <= total_next;
        starts_reg     <= starts_next;
        cents_reg      <= cents_next;
        out_start_reg  <= out_start_next;
        out_center_reg <= out_center_next;
        out_total_reg  <= out_total_next;
        out_np_reg     <= out_np_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_total_reg, out_center_reg, out_start_reg};
    assign m_axis_tuser  = out_np_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[design/svit_checker.sv]
module svit_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a no-path result closes its run with tlast
    a_np_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("no-path result without tlast");

    // a no-path result reports infinity
    a_np_inf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[41:10] == 32'h7fffffff)
        else $error("no-path result with finite score");

    // a run transaction blocks the input while the search is busy
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == svit_pkg::CMD_RUN
            |=> !s_axis_tready)
        else $error("input accepted right after run transaction");

endmodule

bind segmental_viterbi_aligner svit_checker u_svit_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
